// ===== src/thp_pkg.sv =====
// thermal protection block: shared types, register indexes, mode codes and reset values
// no dependencies; used by thp_cfg, thp_step and thermal_protection_fsm
`timescale 1ns / 1ps
`default_nettype none

package thp_pkg;

    localparam int TEMP_W   = 16;
    localparam int TIME_W   = 32;
    localparam int MODE_W   = 2;
    localparam int CFG_DW   = 32;
    localparam int CFG_IW   = 3;
    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 8;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_TEMP_LOW  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_TEMP_HIGH = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_RISE  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PROTECT   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_RECOVERY  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_HOLD_MS   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_COOL_MS   = 3'd6;
    localparam logic [CFG_IW-1:0] REG_SENTINEL  = 3'd7;

    // modes
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROTECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COOL    = 2'd2;

    // register reset values
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW  = -16'sd100;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH = 16'sd3500;
    localparam logic [TEMP_W-1:0]        RST_MAX_RISE  = 16'd100;
    localparam logic signed [TEMP_W-1:0] RST_PROTECT   = 16'sd2800;
    localparam logic signed [TEMP_W-1:0] RST_RECOVERY  = 16'sd2500;
    localparam logic [TIME_W-1:0]        RST_HOLD_MS   = 32'd60000;
    localparam logic [TIME_W-1:0]        RST_COOL_MS   = 32'd30000;
    localparam logic signed [TEMP_W-1:0] RST_SENTINEL  = -16'sd1270;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_low_limit;
        logic signed [TEMP_W-1:0] temp_high_limit;
        logic [TEMP_W-1:0]        max_rise;
        logic signed [TEMP_W-1:0] protect_threshold;
        logic signed [TEMP_W-1:0] recovery_threshold;
        logic [TIME_W-1:0]        protect_hold_ms;
        logic [TIME_W-1:0]        cooldown_ms;
        logic signed [TEMP_W-1:0] error_sentinel;
    } cfg_t;

    typedef struct packed {
        logic              reading_ok;
        logic [MODE_W-1:0] mode_now;
        logic              heat_allowed;
    } result_t;

endpackage

`default_nettype wire

// ===== src/thp_cfg.sv =====
// thermal protection block: configuration register file
// depends on thp_pkg
`timescale 1ns / 1ps
`default_nettype none

module thp_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [thp_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [thp_pkg::CFG_DW-1:0]   cfg_data,
    output thp_pkg::cfg_t                     cfg
);

    thp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_low_limit     <= thp_pkg::RST_TEMP_LOW;
            cfg_reg.temp_high_limit    <= thp_pkg::RST_TEMP_HIGH;
            cfg_reg.max_rise           <= thp_pkg::RST_MAX_RISE;
            cfg_reg.protect_threshold  <= thp_pkg::RST_PROTECT;
            cfg_reg.recovery_threshold <= thp_pkg::RST_RECOVERY;
            cfg_reg.protect_hold_ms    <= thp_pkg::RST_HOLD_MS;
            cfg_reg.cooldown_ms        <= thp_pkg::RST_COOL_MS;
            cfg_reg.error_sentinel     <= thp_pkg::RST_SENTINEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                thp_pkg::REG_TEMP_LOW:  cfg_reg.temp_low_limit     <= cfg_data[15:0];
                thp_pkg::REG_TEMP_HIGH: cfg_reg.temp_high_limit    <= cfg_data[15:0];
                thp_pkg::REG_MAX_RISE:  cfg_reg.max_rise           <= cfg_data[15:0];
                thp_pkg::REG_PROTECT:   cfg_reg.protect_threshold  <= cfg_data[15:0];
                thp_pkg::REG_RECOVERY:  cfg_reg.recovery_threshold <= cfg_data[15:0];
                thp_pkg::REG_HOLD_MS:   cfg_reg.protect_hold_ms    <= cfg_data;
                thp_pkg::REG_COOL_MS:   cfg_reg.cooldown_ms        <= cfg_data;
                thp_pkg::REG_SENTINEL:  cfg_reg.error_sentinel     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/thp_step.sv =====
// thermal protection block: reading check and mode machine with its state registers
// depends on thp_pkg
`timescale 1ns / 1ps
`default_nettype none

module thp_step (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire thp_pkg::cfg_t                      cfg,
    input  wire logic                               fire,
    input  wire logic signed [thp_pkg::TEMP_W-1:0]  temperature,
    input  wire logic [thp_pkg::TIME_W-1:0]         now_ms,
    output thp_pkg::result_t                        res
);

    logic [thp_pkg::MODE_W-1:0]        mode_reg, mode_next;
    logic [thp_pkg::TIME_W-1:0]        entry_reg, entry_next;
    logic signed [thp_pkg::TEMP_W-1:0] last_reg, last_next;

    logic                              ok;
    logic                              last_pos;
    logic signed [thp_pkg::TEMP_W+1:0] rise;
    logic signed [thp_pkg::TEMP_W+1:0] rise_lim;
    logic [thp_pkg::TIME_W-1:0]        dur;
    logic                              heat;
    logic                              hot;

    always_comb
    begin
        last_pos = !last_reg[thp_pkg::TEMP_W-1] && (last_reg != '0);
        rise     = {{2{temperature[thp_pkg::TEMP_W-1]}}, temperature}
                 - {{2{last_reg[thp_pkg::TEMP_W-1]}}, last_reg};
        rise_lim = {2'b00, cfg.max_rise};
        ok = (temperature != cfg.error_sentinel)
          && (temperature >= cfg.temp_low_limit)
          && (temperature <= cfg.temp_high_limit)
          && !(last_pos && (rise > rise_lim));
        dur = now_ms - entry_reg;
        hot = (temperature >= cfg.protect_threshold);
    end

    always_comb
    begin
        mode_next  = mode_reg;
        entry_next = entry_reg;
        last_next  = last_reg;
        heat       = 1'b0;
        case (mode_reg)
            thp_pkg::MODE_NORMAL:
            begin
                heat = 1'b1;
                if (ok)
                begin
                    last_next = temperature;
                    if (hot)
                    begin
                        mode_next  = thp_pkg::MODE_PROTECT;
                        entry_next = now_ms;
                        heat       = 1'b0;
                    end
                end
            end
            thp_pkg::MODE_PROTECT:
            begin
                if (ok)
                begin
                    last_next = temperature;
                    if ((dur >= cfg.protect_hold_ms)
                        && (temperature <= cfg.recovery_threshold))
                    begin
                        mode_next  = thp_pkg::MODE_COOL;
                        entry_next = now_ms;
                    end
                end
            end
            thp_pkg::MODE_COOL:
            begin
                if (ok)
                begin
                    last_next = temperature;
                    if (hot)
                    begin
                        mode_next  = thp_pkg::MODE_PROTECT;
                        entry_next = now_ms;
                    end
                    else if (dur >= cfg.cooldown_ms)
                    begin
                        mode_next  = thp_pkg::MODE_NORMAL;
                        entry_next = now_ms;
                        heat       = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused code: fall back to normal
                mode_next  = thp_pkg::MODE_NORMAL;
                entry_next = now_ms;
                heat       = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= thp_pkg::MODE_NORMAL;
            entry_reg <= '0;
            last_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            entry_reg <= entry_next;
            last_reg  <= last_next;
        end
    end

    assign res.reading_ok   = ok;
    assign res.mode_now     = mode_next;
    assign res.heat_allowed = heat;

endmodule

`default_nettype wire

// ===== src/thermal_protection_fsm.sv =====
// thermal protection block: top level with input word register and result register
// depends on thp_pkg, thp_cfg, thp_step
`timescale 1ns / 1ps
`default_nettype none

// path: input register then result register; m_tvalid rises once the word has moved from the
//   input register into the result register, which waits while a held result is not taken
// throughput: one word per cycle while m_tready is not held low; the mode state is read and
//   updated in the single compare stage between the input register and the result register
// reset: rst_n asynchronous, active low; mode returns to normal, entry time and last
//   valid reading clear, configuration registers take their default values
module thermal_protection_fsm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [thp_pkg::IN_DW-1:0]     s_tdata,   // [15:0] temperature, [47:16] now_ms
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [thp_pkg::OUT_DW-1:0]         m_tdata,   // [0] heat_allowed, [2:1] mode_now,
                                                          // [3] reading_ok, [7:4] zero
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [thp_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [thp_pkg::CFG_DW-1:0]    cfg_data
);

    thp_pkg::cfg_t    cfg;
    thp_pkg::result_t res;

    // input word register
    logic                              in_valid_reg;
    logic signed [thp_pkg::TEMP_W-1:0] temp_reg;
    logic [thp_pkg::TIME_W-1:0]        now_reg;

    // result register
    logic                              out_valid_reg;
    thp_pkg::result_t                  out_reg;

    logic move;      // input register word goes through the step into the result register
    logic take_in;

    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign take_in  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            temp_reg <= s_tdata[15:0];
            now_reg  <= s_tdata[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg <= res;
        end
    end

    thp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state advances only when the word actually moves on
    thp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (move),
        .temperature (temp_reg),
        .now_ms      (now_reg),
        .res         (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.reading_ok, out_reg.mode_now, out_reg.heat_allowed};

endmodule

`default_nettype wire

// ===== sim/thermal_protection_fsm_tb.sv =====
// testbench for thermal_protection_fsm: directed and random heater readings checked word by word
// against a local model of the reading filter and the normal / protection / cooldown machine
// depends on thp_pkg and the thermal_protection_fsm rtl
`timescale 1ns / 1ps

module thermal_protection_fsm_tb;

    import thp_pkg::*;

    // limit on the run length; a correct run with full stalls on both sides ends well before it
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;   // [15:0] temperature, [47:16] now_ms
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;   // [0] heat_allowed, [2:1] mode_now, [3] reading_ok, [7:4] zero
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    thermal_protection_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the limits; temperature limits are plain integers so their compares are signed, times are unsigned
    int          lim_low     = RST_TEMP_LOW;
    int          lim_high    = RST_TEMP_HIGH;
    int          rise_max    = RST_MAX_RISE;
    int          thr_protect = RST_PROTECT;
    int          thr_recover = RST_RECOVERY;
    logic [31:0] hold_ms     = RST_HOLD_MS;
    logic [31:0] cool_ms     = RST_COOL_MS;
    int          fault_code  = RST_SENTINEL;

    // local copy of the machine state
    logic [MODE_W-1:0] fsm_mode   = MODE_NORMAL;
    logic [31:0]       mode_since = '0;
    int                last_good  = 0;

    // expected result words, oldest first
    result_t expected_results[$];

    bit          idle_on = 1'b0;
    logic [31:0] stamp_ms = '0;
    int          error_count = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int          n_rejected = 0;
    int          n_protect = 0;
    int          n_cool = 0;
    int          n_normal = 0;
    int          cycle_count = 0;

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout: a hung handshake or a lost word ends the run here
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                 expected_results.size());
        $display("thermal_protection_fsm_tb NOT OK");
        $finish;
    end

    // result side backpressure: random stall bursts while idling is on
    initial
    begin : sink_stalls
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch in %s at result word %0d: got %0d, expected %0d", what, n_checked,
                 got, want);
        error_count++;
    endtask

    // every accepted result word is compared with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[3:0]);
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", m_tdata, 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.heat_allowed != want.heat_allowed)
                    report_mismatch("heat_allowed", got.heat_allowed, want.heat_allowed);
                if (got.mode_now != want.mode_now)
                    report_mismatch("mode_now", got.mode_now, want.mode_now);
                if (got.reading_ok != want.reading_ok)
                    report_mismatch("reading_ok", got.reading_ok, want.reading_ok);
                if (m_tdata[7:4] != '0)
                    report_mismatch("pad bits", m_tdata[7:4], 0);
            end
            n_checked++;
        end
    end

    // one reading through the filter and the mode machine; updates the local state
    function automatic result_t predict_reading(input int temp, input logic [31:0] stamp);
        result_t     r;
        logic        ok;
        logic        heat;
        logic [31:0] dwell;
        ok = (temp != fault_code) && (temp >= lim_low) && (temp <= lim_high);
        // rise limit only applies once the last good reading is above zero
        if (last_good > 0 && temp - last_good > rise_max)
            ok = 1'b0;
        if (!ok)
            n_rejected++;
        dwell = stamp - mode_since;     // wraps modulo 2^32 like the time stamp
        case (fsm_mode)
            MODE_NORMAL:
            begin
                heat = 1'b1;
                if (ok)
                begin
                    last_good = temp;
                    if (temp >= thr_protect)
                    begin
                        fsm_mode = MODE_PROTECT;
                        mode_since = stamp;
                        heat = 1'b0;
                        n_protect++;
                    end
                end
            end
            MODE_PROTECT:
            begin
                heat = 1'b0;
                if (ok)
                begin
                    last_good = temp;
                    if (dwell >= hold_ms && temp <= thr_recover)
                    begin
                        fsm_mode = MODE_COOL;
                        mode_since = stamp;
                        n_cool++;
                    end
                end
            end
            MODE_COOL:
            begin
                heat = 1'b0;
                if (ok)
                begin
                    last_good = temp;
                    // a hot reading wins over an expired cooldown
                    if (temp >= thr_protect)
                    begin
                        fsm_mode = MODE_PROTECT;
                        mode_since = stamp;
                        n_protect++;
                    end
                    else if (dwell >= cool_ms)
                    begin
                        fsm_mode = MODE_NORMAL;
                        mode_since = stamp;
                        heat = 1'b1;
                        n_normal++;
                    end
                end
            end
            default:
            begin
                // unused code falls back to normal
                fsm_mode = MODE_NORMAL;
                mode_since = stamp;
                heat = 1'b1;
            end
        endcase
        r.heat_allowed = heat;
        r.mode_now = fsm_mode;
        r.reading_ok = ok;
        return r;
    endfunction

    // sends one word; entered and left at a falling edge, tvalid stays high on exit
    task automatic send_reading(input int temp, input logic [31:0] stamp);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {stamp, temp[15:0]};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_reading(temp, stamp));
        n_sent++;
        @(negedge clk);
    endtask

    // lets the block drain; every word causes a result, the pause covers the pipeline
    task automatic settle();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_TEMP_LOW:  lim_low = $signed(data[15:0]);
            REG_TEMP_HIGH: lim_high = $signed(data[15:0]);
            REG_MAX_RISE:  rise_max = data[15:0];
            REG_PROTECT:   thr_protect = $signed(data[15:0]);
            REG_RECOVERY:  thr_recover = $signed(data[15:0]);
            REG_HOLD_MS:   hold_ms = data;
            REG_COOL_MS:   cool_ms = data;
            REG_SENTINEL:  fault_code = $signed(data[15:0]);
            default: ;
        endcase
    endtask

    // writes all eight registers while idle; upper bits of the 16-bit ones carry junk
    task automatic apply_settings(input int lo, input int hi, input int rise, input int prot,
                                  input int rec, input logic [31:0] hold,
                                  input logic [31:0] cool, input int sent);
        settle();
        write_register(REG_TEMP_LOW,  {16'($urandom), lo[15:0]});
        write_register(REG_TEMP_HIGH, {16'($urandom), hi[15:0]});
        write_register(REG_MAX_RISE,  {16'($urandom), rise[15:0]});
        write_register(REG_PROTECT,   {16'($urandom), prot[15:0]});
        write_register(REG_RECOVERY,  {16'($urandom), rec[15:0]});
        write_register(REG_HOLD_MS,   hold);
        write_register(REG_COOL_MS,   cool);
        write_register(REG_SENTINEL,  {16'($urandom), sent[15:0]});
        n_settings++;
    endtask

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    // mostly a plausible temperature walk steered by the current mode, so protection
    // and cooldown are entered and left; the rest are limit values and raw noise
    task automatic send_random_readings(input int count, input int unsigned step_max);
        int span;
        int delta;
        int pick;
        int temp;
        span = (rise_max == 0) ? 40 : (rise_max > 400) ? 400 : rise_max;
        if ($urandom_range(0, 3) == 0)
            stamp_ms = 32'hFFFF_FF00;   // start close to the time stamp wrap
        else
            stamp_ms = $urandom;
        repeat (count)
        begin
            stamp_ms += $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                case (fsm_mode)
                    MODE_NORMAL:  delta = int'($urandom_range(0, span + span / 2)) - span / 2;
                    MODE_PROTECT: delta = int'($urandom_range(0, span + span / 3)) - span;
                    default:      delta = int'($urandom_range(0, span + span / 2)) - span;
                endcase
                temp = clamp16(last_good + delta);
                // occasional flare-up during cooldown
                if (fsm_mode == MODE_COOL && $urandom_range(0, 9) == 0)
                    temp = thr_protect;
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 10))
                    0:       temp = lim_low - 1;
                    1:       temp = lim_low;
                    2:       temp = lim_high;
                    3:       temp = lim_high + 1;
                    4:       temp = fault_code;
                    5:       temp = thr_protect - 1;
                    6:       temp = thr_protect;
                    7:       temp = thr_recover;
                    8:       temp = thr_recover + 1;
                    9:       temp = last_good + rise_max;
                    default: temp = last_good + rise_max + 1;
                endcase
                temp = clamp16(temp);
            end
            else
            begin
                temp = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 2) == 0)
                    stamp_ms = $urandom;
            end
            send_reading(temp, stamp_ms);
        end
    endtask

    // default limits: each validity rule, hold and cooldown boundaries, time stamp wrap
    task automatic test_directed_defaults();
        logic [31:0] t0;
        t0 = 32'hFFFF_8000;
        idle_on = 1'b1;
        send_reading(0, t0);
        send_reading(-32768, t0 + 1);
        send_reading(32767, t0 + 2);
        send_reading(fault_code, t0 + 3);
        send_reading(lim_low - 1, t0 + 4);
        send_reading(1500, t0 + 5);             // last good is 0, no rise limit
        send_reading(lim_low, t0 + 6);
        send_reading(lim_high + 1, t0 + 7);
        send_reading(lim_high, t0 + 8);         // last good negative, straight to protection
        // hold time runs across the time stamp wrap
        send_reading(2500, mode_since + hold_ms - 1);
        send_reading(2501, mode_since + hold_ms);
        send_reading(2500, mode_since + hold_ms + 1);
        send_reading(2600, mode_since + 1);     // rise exactly at the limit
        send_reading(2701, mode_since + 2);     // one over the limit
        send_reading(2700, mode_since + 3);
        send_reading(2800, mode_since + 4);     // cooldown back to protection
        send_reading(fault_code, mode_since + 70000);
        send_reading(2450, mode_since + 70000);
        send_reading(2000, mode_since + cool_ms - 1);
        send_reading(2000, mode_since + cool_ms);
        send_reading(2101, mode_since + 1);     // rejected but heating stays on
        send_reading(2100, mode_since + 2);
        send_reading(2199, mode_since + 2);
    endtask

    task automatic test_default_walk();
        idle_on = 1'b1;
        send_random_readings(300, 20000);
    endtask

    // short timers and a sentinel inside the plausible range
    task automatic test_fast_timers();
        idle_on = 1'b1;
        apply_settings(-500, 3000, 200, 1000, 800, 100, 50, 900);
        send_random_readings(320, 40);
    endtask

    // widest limits, zero timers, no idling on either side
    task automatic test_wide_limits();
        idle_on = 1'b0;
        apply_settings(-32768, 32767, 65535, 32767, -32768, 0, 0, 0);
        send_random_readings(150, 1000);
    endtask

    // low limit above high limit: nothing is ever valid
    task automatic test_inverted_limits();
        idle_on = 1'b1;
        apply_settings(32767, -32768, 0, -32768, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32767);
        send_random_readings(60, 100000);
    endtask

    // no rise allowed once the last good reading is positive
    task automatic test_zero_rise();
        idle_on = 1'b1;
        apply_settings(-200, 600, 0, 400, 100, 20, 10, 300);
        send_random_readings(250, 10);
    endtask

    task automatic test_random_settings();
        int lo;
        int prot;
        idle_on = 1'b1;
        repeat (5)
        begin
            lo = -int'($urandom_range(0, 2000));
            prot = $urandom_range(200, 3000);
            apply_settings(lo, $urandom_range(prot, 4000), $urandom_range(0, 500), prot,
                           prot - int'($urandom_range(0, 800)), $urandom_range(0, 300),
                           $urandom_range(0, 300), ($urandom_range(0, 3) == 0) ? lo + 50 : -1270);
            send_random_readings(50, 60);
        end
    endtask

    // back-to-back words with no stalls to close the run
    task automatic test_steady_stream();
        apply_settings(-100, 3500, 100, 600, 400, 200, 100, -1270);
        idle_on = 1'b0;
        send_random_readings(200, 30);
    endtask

    initial
    begin : main_sequence
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_defaults();
        test_default_walk();
        test_fast_timers();
        test_wide_limits();
        test_inverted_limits();
        test_zero_rise();
        test_random_settings();
        test_steady_stream();

        settle();
        repeat (10) @(posedge clk);
        $display("%0d readings sent, %0d result words checked, %0d register settings, %0d rejected",
                 n_sent, n_checked, n_settings, n_rejected);
        $display("mode changes: %0d into protection, %0d into cooldown, %0d back to normal",
                 n_protect, n_cool, n_normal);
        if (error_count == 0)
            $display("thermal_protection_fsm_tb OK");
        else
            $display("thermal_protection_fsm_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/thp_pkg.sv
src/thp_cfg.sv
src/thp_step.sv
src/thermal_protection_fsm.sv
sim/thermal_protection_fsm_tb.sv
